>>> hdl/tft_pkg.sv
// ----------------------------------------------------------------------------
// tft_pkg
// Types and constants shared by the triangle tangent controller, datapath,
// result stage and top level.
// ----------------------------------------------------------------------------
package tft_pkg;

	localparam int TAN_W    = 32;
	localparam int DELTA_W  = 33;
	localparam int PROD_W   = 66;
	localparam int ACC_W    = 67;
	localparam int MAG_W    = 66;
	localparam int QUO_W    = 33;
	localparam int CNT_W    = 6;
	localparam int STEP_W   = 3;
	localparam int AXES     = 3;

	localparam int MUL_STEPS = 8;
	localparam int DIV_STEPS = 33;

	localparam logic [1:0] LAST_CORNER = 2'd2;
	localparam logic [1:0] MID_CORNER  = 2'd1;

	// multiplier schedule
	localparam logic [STEP_W-1:0] STEP_DET_A = 3'd0;
	localparam logic [STEP_W-1:0] STEP_DET_B = 3'd1;

	localparam logic [QUO_W-1:0] QUO_MAX_POS = 33'h0_7FFF_FFFF;
	localparam logic [QUO_W-1:0] QUO_MAX_NEG = 33'h0_8000_0000;
	localparam logic [TAN_W-1:0] TAN_SAT_POS = 32'h7FFF_FFFF;
	localparam logic [TAN_W-1:0] TAN_SAT_NEG = 32'h8000_0000;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_PREP,
		ST_DIV_INIT,
		ST_DIV,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic              hold_wr;
		logic              hold_slot;
		logic              delta_ld;
		logic              mul_issue;
		logic [STEP_W-1:0] mul_step;
		logic              prep;
		logic              div_init;
		logic              div_step;
		logic              out_load;
	} cmd_t;

	typedef struct packed {
		logic [TAN_W-1:0] tan_x;
		logic [TAN_W-1:0] tan_y;
		logic [TAN_W-1:0] tan_z;
		logic             degen;
	} res_t;

endpackage

>>> hdl/tft_ctrl.sv
// ----------------------------------------------------------------------------
// tft_ctrl
// Sequencer: counts corners, runs the multiplier schedule, the divider
// iterations and hands the finished tangent to the result stage.
// ----------------------------------------------------------------------------
module tft_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic          out_busy,
	output tft_pkg::cmd_t cmd
);

	tft_pkg::state_t              state_q, state_d;
	logic [tft_pkg::CNT_W-1:0]    cnt_q;
	logic [1:0]                   corner_q;
	logic                         accept;

	assign accept = in_valid && (state_q == tft_pkg::ST_IDLE);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tft_pkg::ST_IDLE: begin
				if (accept && corner_q == tft_pkg::LAST_CORNER)
					state_d = tft_pkg::ST_MUL;
			end
			tft_pkg::ST_MUL: begin
				if (cnt_q == tft_pkg::CNT_W'(tft_pkg::MUL_STEPS))
					state_d = tft_pkg::ST_PREP;
			end
			tft_pkg::ST_PREP:     state_d = tft_pkg::ST_DIV_INIT;
			tft_pkg::ST_DIV_INIT: state_d = tft_pkg::ST_DIV;
			tft_pkg::ST_DIV: begin
				if (cnt_q == tft_pkg::CNT_W'(tft_pkg::DIV_STEPS - 1))
					state_d = tft_pkg::ST_DONE;
			end
			tft_pkg::ST_DONE: begin
				if (!out_busy)
					state_d = tft_pkg::ST_IDLE;
			end
			default: state_d = tft_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			tft_pkg::ST_IDLE: begin
				in_stall      = 1'b0;
				cmd.hold_slot = (corner_q == tft_pkg::MID_CORNER);
				cmd.hold_wr   = accept && (corner_q != tft_pkg::LAST_CORNER);
				cmd.delta_ld  = accept && (corner_q == tft_pkg::LAST_CORNER);
			end
			tft_pkg::ST_MUL: begin
				cmd.mul_issue = (cnt_q < tft_pkg::CNT_W'(tft_pkg::MUL_STEPS));
				cmd.mul_step  = cnt_q[tft_pkg::STEP_W-1:0];
			end
			tft_pkg::ST_PREP:     cmd.prep     = 1'b1;
			tft_pkg::ST_DIV_INIT: cmd.div_init = 1'b1;
			tft_pkg::ST_DIV:      cmd.div_step = 1'b1;
			tft_pkg::ST_DONE:     cmd.out_load = !out_busy;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= tft_pkg::ST_IDLE;
			cnt_q    <= '0;
			corner_q <= '0;
		end else begin
			state_q <= state_d;
			if ((state_q == tft_pkg::ST_MUL || state_q == tft_pkg::ST_DIV)
					&& state_d == state_q)
				cnt_q <= cnt_q + 1'b1;
			else
				cnt_q <= '0;
			if (accept) begin
				if (corner_q == tft_pkg::LAST_CORNER)
					corner_q <= '0;
				else if (corner_q == tft_pkg::MID_CORNER)
					corner_q <= tft_pkg::LAST_CORNER;
				else
					corner_q <= tft_pkg::MID_CORNER;
			end
		end
	end

endmodule

>>> hdl/tft_dp.sv
// ----------------------------------------------------------------------------
// tft_dp
// Datapath: held corners, edge deltas, one shared multiplier with a
// subtracting accumulator, and three restoring dividers on a common divisor.
// ----------------------------------------------------------------------------
module tft_dp #(
	parameter int FRACTION_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tft_pkg::cmd_t        cmd,
	input  logic signed [31:0]   pos_x,
	input  logic signed [31:0]   pos_y,
	input  logic signed [31:0]   pos_z,
	input  logic signed [31:0]   tex_u,
	input  logic signed [31:0]   tex_v,
	output tft_pkg::res_t        res
);

	localparam int DIV_W = tft_pkg::MAG_W + tft_pkg::QUO_W + 1;

	logic signed [31:0]                    in_pos [tft_pkg::AXES];
	logic signed [31:0]                    held_pos_q [6];
	logic signed [31:0]                    held_tex_q [4];

	logic signed [tft_pkg::DELTA_W-1:0]    dp1_q [tft_pkg::AXES];
	logic signed [tft_pkg::DELTA_W-1:0]    dp2_q [tft_pkg::AXES];
	logic signed [tft_pkg::DELTA_W-1:0]    du1_q, dv1_q, du2_q, dv2_q;

	logic signed [tft_pkg::DELTA_W-1:0]    mul_a, mul_b;
	logic [1:0]                            mul_axis;
	logic signed [tft_pkg::PROD_W-1:0]     prod_s1;
	logic [tft_pkg::STEP_W-1:0]            tag_s1;
	logic                                  tag_vld_s1;
	logic signed [tft_pkg::ACC_W-1:0]      acc_q, diff;
	logic [1:0]                            diff_axis;

	logic signed [tft_pkg::ACC_W-1:0]      det_q;
	logic signed [tft_pkg::ACC_W-1:0]      num_q [tft_pkg::AXES];
	logic [tft_pkg::ACC_W-1:0]             det_neg_full;
	logic [tft_pkg::ACC_W-1:0]             num_neg_full [tft_pkg::AXES];

	logic [tft_pkg::MAG_W-1:0]             det_mag_q;
	logic                                  det_zero_q;
	logic [tft_pkg::MAG_W-1:0]             num_mag_q [tft_pkg::AXES];
	logic                                  neg_q [tft_pkg::AXES];

	logic [DIV_W-1:0]                      rem_q [tft_pkg::AXES];
	logic [DIV_W-1:0]                      dvs_q;
	logic [tft_pkg::QUO_W-1:0]             quo_q [tft_pkg::AXES];
	logic                                  ovf_q [tft_pkg::AXES];

	logic [tft_pkg::TAN_W-1:0]             tan [tft_pkg::AXES];
	logic                                  sat [tft_pkg::AXES];

	assign in_pos[0] = pos_x;
	assign in_pos[1] = pos_y;
	assign in_pos[2] = pos_z;

	// held corners and edge deltas
	always_ff @(posedge clk) begin
		if (cmd.hold_wr) begin
			if (cmd.hold_slot) begin
				for (int k = 0; k < tft_pkg::AXES; k++)
					held_pos_q[3 + k] <= in_pos[k];
				held_tex_q[2] <= tex_u;
				held_tex_q[3] <= tex_v;
			end else begin
				for (int k = 0; k < tft_pkg::AXES; k++)
					held_pos_q[k] <= in_pos[k];
				held_tex_q[0] <= tex_u;
				held_tex_q[1] <= tex_v;
			end
		end
		if (cmd.delta_ld) begin
			for (int k = 0; k < tft_pkg::AXES; k++) begin
				dp1_q[k] <= tft_pkg::DELTA_W'(held_pos_q[3 + k])
					- tft_pkg::DELTA_W'(held_pos_q[k]);
				dp2_q[k] <= tft_pkg::DELTA_W'(in_pos[k])
					- tft_pkg::DELTA_W'(held_pos_q[k]);
			end
			du1_q <= tft_pkg::DELTA_W'(held_tex_q[2]) - tft_pkg::DELTA_W'(held_tex_q[0]);
			dv1_q <= tft_pkg::DELTA_W'(held_tex_q[3]) - tft_pkg::DELTA_W'(held_tex_q[1]);
			du2_q <= tft_pkg::DELTA_W'(tex_u) - tft_pkg::DELTA_W'(held_tex_q[0]);
			dv2_q <= tft_pkg::DELTA_W'(tex_v) - tft_pkg::DELTA_W'(held_tex_q[1]);
		end
	end

	// operand select for the shared multiplier
	assign mul_axis = cmd.mul_step[2:1] - 2'd1;

	always_comb begin
		unique case (cmd.mul_step)
			tft_pkg::STEP_DET_A: begin
				mul_a = du1_q;
				mul_b = dv2_q;
			end
			tft_pkg::STEP_DET_B: begin
				mul_a = dv1_q;
				mul_b = du2_q;
			end
			default: begin
				if (cmd.mul_step[0]) begin
					mul_a = dp2_q[mul_axis];
					mul_b = dv1_q;
				end else begin
					mul_a = dp1_q[mul_axis];
					mul_b = dv2_q;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			tag_vld_s1 <= 1'b0;
		else
			tag_vld_s1 <= cmd.mul_issue;
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_issue) begin
			prod_s1 <= mul_a * mul_b;
			tag_s1  <= cmd.mul_step;
		end
	end

	// even steps load the accumulator, odd steps subtract and store
	assign diff      = acc_q - tft_pkg::ACC_W'(prod_s1);
	assign diff_axis = tag_s1[2:1] - 2'd1;

	always_ff @(posedge clk) begin
		if (tag_vld_s1) begin
			if (!tag_s1[0])
				acc_q <= tft_pkg::ACC_W'(prod_s1);
			else if (tag_s1 == tft_pkg::STEP_DET_B)
				det_q <= diff;
			else
				num_q[diff_axis] <= diff;
		end
	end

	// magnitudes and signs
	always_comb begin
		det_neg_full = -det_q;
		for (int k = 0; k < tft_pkg::AXES; k++)
			num_neg_full[k] = -num_q[k];
	end

	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			det_mag_q  <= det_q[tft_pkg::ACC_W-1] ? det_neg_full[tft_pkg::MAG_W-1:0]
				: det_q[tft_pkg::MAG_W-1:0];
			det_zero_q <= (det_q == '0);
			for (int k = 0; k < tft_pkg::AXES; k++) begin
				num_mag_q[k] <= num_q[k][tft_pkg::ACC_W-1]
					? num_neg_full[k][tft_pkg::MAG_W-1:0] : num_q[k][tft_pkg::MAG_W-1:0];
				neg_q[k] <= num_q[k][tft_pkg::ACC_W-1] ^ det_q[tft_pkg::ACC_W-1];
			end
		end
	end

	// restoring division, one quotient bit per cycle per axis
	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			dvs_q <= DIV_W'(det_mag_q) << (tft_pkg::QUO_W - 1);
			for (int k = 0; k < tft_pkg::AXES; k++) begin
				rem_q[k] <= DIV_W'(num_mag_q[k]) << FRACTION_BITS;
				ovf_q[k] <= (DIV_W'(num_mag_q[k]) << FRACTION_BITS)
					>= (DIV_W'(det_mag_q) << tft_pkg::QUO_W);
				quo_q[k] <= '0;
			end
		end else if (cmd.div_step) begin
			dvs_q <= dvs_q >> 1;
			for (int k = 0; k < tft_pkg::AXES; k++) begin
				if (rem_q[k] >= dvs_q) begin
					rem_q[k] <= rem_q[k] - dvs_q;
					quo_q[k] <= {quo_q[k][tft_pkg::QUO_W-2:0], 1'b1};
				end else begin
					quo_q[k] <= {quo_q[k][tft_pkg::QUO_W-2:0], 1'b0};
				end
			end
		end
	end

	// sign, saturation and zero determinant
	always_comb begin
		for (int k = 0; k < tft_pkg::AXES; k++) begin
			if (neg_q[k]) begin
				sat[k] = ovf_q[k] || (quo_q[k] > tft_pkg::QUO_MAX_NEG);
				tan[k] = sat[k] ? tft_pkg::TAN_SAT_NEG
					: tft_pkg::TAN_W'(0) - quo_q[k][tft_pkg::TAN_W-1:0];
			end else begin
				sat[k] = ovf_q[k] || (quo_q[k] > tft_pkg::QUO_MAX_POS);
				tan[k] = sat[k] ? tft_pkg::TAN_SAT_POS : quo_q[k][tft_pkg::TAN_W-1:0];
			end
		end
		if (det_zero_q) begin
			res.tan_x = '0;
			res.tan_y = '0;
			res.tan_z = '0;
			res.degen = 1'b1;
		end else begin
			res.tan_x = tan[0];
			res.tan_y = tan[1];
			res.tan_z = tan[2];
			res.degen = sat[0] || sat[1] || sat[2];
		end
	end

endmodule

>>> hdl/tft_out.sv
// ----------------------------------------------------------------------------
// tft_out
// Result stage: holds one triangle's tangent and sends it once per corner.
// ----------------------------------------------------------------------------
module tft_out (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  tft_pkg::res_t       res,
	output logic                busy,
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [31:0]  tangent_x,
	output logic signed [31:0]  tangent_y,
	output logic signed [31:0]  tangent_z,
	output logic [1:0]          corner_index,
	output logic                degenerate,
	output logic                last_of_triangle
);

	tft_pkg::res_t res_q;
	logic [1:0]    idx_q;
	logic          valid_q;
	logic          xfer;

	assign xfer = valid_q && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (load) begin
			valid_q <= 1'b1;
			idx_q   <= '0;
		end else if (xfer) begin
			if (idx_q == tft_pkg::LAST_CORNER)
				valid_q <= 1'b0;
			idx_q <= idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			res_q <= res;
	end

	assign busy             = valid_q;
	assign out_valid        = valid_q;
	assign tangent_x        = res_q.tan_x;
	assign tangent_y        = res_q.tan_y;
	assign tangent_z        = res_q.tan_z;
	assign corner_index     = idx_q;
	assign degenerate       = res_q.degen;
	assign last_of_triangle = (idx_q == tft_pkg::LAST_CORNER);

endmodule

>>> hdl/triangle_tangent_from_uv_top.sv
// ----------------------------------------------------------------------------
// triangle_tangent_from_uv_top
// Per-triangle tangent from position and uv edge deltas, signed fixed point.
//
// Input channel (in_valid / in_stall) takes one vertex per transfer; every
// three vertices form a triangle. Output channel (out_valid / out_stall)
// gives three results per triangle, one per corner, with the same tangent,
// corner_index 0..2 and last_of_triangle on the third.
// The first two vertices are only held. The third runs the shared 33x33
// multiplier (8 products), then signs and divider setup, then the
// bit-serial dividers (one quotient bit a cycle, three axes side by
// side), then the hand-over; no vertex is taken until the hand-over.
// The result stage holds a finished triangle, so the next triangle's
// corners are taken while the receiver stalls; a second finished triangle
// waits in the datapath until the result stage is empty.
// Reset clears the corner count and all handshake state; the next vertex
// is corner 0.
// ----------------------------------------------------------------------------
module triangle_tangent_from_uv_top #(
	parameter int FRACTION_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic signed [31:0] tex_u,
	input  logic signed [31:0] tex_v,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] tangent_x,
	output logic signed [31:0] tangent_y,
	output logic signed [31:0] tangent_z,
	output logic [1:0]         corner_index,
	output logic               degenerate,
	output logic               last_of_triangle
);

	tft_pkg::cmd_t cmd;
	tft_pkg::res_t res;
	logic          out_busy;

	tft_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_busy (out_busy),
		.cmd      (cmd)
	);

	tft_dp #(
		.FRACTION_BITS (FRACTION_BITS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.pos_x  (pos_x),
		.pos_y  (pos_y),
		.pos_z  (pos_z),
		.tex_u  (tex_u),
		.tex_v  (tex_v),
		.res    (res)
	);

	tft_out u_out (
		.clk              (clk),
		.arst_n           (arst_n),
		.load             (cmd.out_load),
		.res              (res),
		.busy             (out_busy),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.tangent_x        (tangent_x),
		.tangent_y        (tangent_y),
		.tangent_z        (tangent_z),
		.corner_index     (corner_index),
		.degenerate       (degenerate),
		.last_of_triangle (last_of_triangle)
	);

endmodule

>>> hdl/tft_check.sv
// ----------------------------------------------------------------------------
// tft_check
// Port-level checks on the result sequence of the triangle tangent block.
// ----------------------------------------------------------------------------
module tft_check (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_stall,
	input logic signed [31:0] tangent_x,
	input logic signed [31:0] tangent_y,
	input logic signed [31:0] tangent_z,
	input logic [1:0]         corner_index,
	input logic               degenerate,
	input logic               last_of_triangle
);

	// stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// corners follow each other without a gap
	a_corner_next: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_of_triangle |=>
			out_valid && corner_index == $past(corner_index) + 2'd1)
		else $error("corner sequence broken");

	// last flag marks the third corner only
	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> last_of_triangle == (corner_index == 2'd2))
		else $error("last_of_triangle mismatch");

	// all corners of one triangle carry the same tangent
	a_same_tangent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_of_triangle |=>
			$stable(tangent_x) && $stable(tangent_y) && $stable(tangent_z)
			&& $stable(degenerate))
		else $error("tangent changed within a triangle");

endmodule

bind triangle_tangent_from_uv_top tft_check u_tft_check (.*);

>>> bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Streams vertices into the triangle tangent block and checks every result
// against a tangent computed here from the uv and position edge deltas:
// directed triangles first (unit basis, zero determinant, saturation both
// ways, negative determinant, exact most-negative tangent, field extremes),
// then random triangles of several shapes. Both channels see random gaps.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int FRAC = 16;
	localparam int ONE = 1 << FRAC;
	localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
	localparam int QUIET_LIMIT = 3000;
	localparam int DRAIN_CYCLES = 100;
	localparam int RANDOM_TRIANGLES = 26;

	typedef struct {
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [31:0] pz;
		logic signed [31:0] tu;
		logic signed [31:0] tv;
	} vertex_t;

	typedef struct {
		logic [tft_pkg::TAN_W-1:0] tx;
		logic [tft_pkg::TAN_W-1:0] ty;
		logic [tft_pkg::TAN_W-1:0] tz;
		logic [1:0]                corner;
		logic                      degen;
		logic                      last;
	} tangent_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic signed [31:0] pos_x = '0;
	logic signed [31:0] pos_y = '0;
	logic signed [31:0] pos_z = '0;
	logic signed [31:0] tex_u = '0;
	logic signed [31:0] tex_v = '0;
	logic               out_valid;
	logic               out_stall = 1'b1;
	logic signed [31:0] tangent_x;
	logic signed [31:0] tangent_y;
	logic signed [31:0] tangent_z;
	logic [1:0]         corner_index;
	logic               degenerate;
	logic               last_of_triangle;

	vertex_t  vertex_queue[$];
	tangent_t tangents_due[$];
	vertex_t  on_wire;
	int       gap_left = 0;
	int       hold_left = 0;
	int       vertices_taken = 0;
	int       results_seen = 0;
	int       mismatches = 0;
	int       quiet_cycles = 0;

	logic signed [31:0] corner_pos[6];
	logic signed [31:0] corner_uv[4];
	logic [1:0]         corners_held = '0;

	triangle_tangent_from_uv_top #(
		.FRACTION_BITS(FRAC)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.pos_x(pos_x),
		.pos_y(pos_y),
		.pos_z(pos_z),
		.tex_u(tex_u),
		.tex_v(tex_v),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.tangent_x(tangent_x),
		.tangent_y(tangent_y),
		.tangent_z(tangent_z),
		.corner_index(corner_index),
		.degenerate(degenerate),
		.last_of_triangle(last_of_triangle)
	);

	always #2 clk = ~clk;

	function automatic int pick_gap(input bit calm);
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic int span(input int unsigned lim);
		return int'($urandom_range(0, 2 * lim)) - int'(lim);
	endfunction

	function automatic void add_vertex(input int x, input int y, input int z, input int u,
			input int v);
		vertex_t w;
		w.px = x;
		w.py = y;
		w.pz = z;
		w.tu = u;
		w.tv = v;
		vertex_queue = {vertex_queue, w};
	endfunction

	// holds corners 0 and 1, on corner 2 queues the three tangent results
	task automatic absorb_vertex(input vertex_t v);
		logic signed [31:0]        p[3];
		logic signed [32:0]        dp1[3];
		logic signed [32:0]        dp2[3];
		logic signed [32:0]        du1, dv1, du2, dv2;
		logic signed [66:0]        det, num;
		logic signed [127:0]       wide;
		logic [127:0]              det_mag, quo;
		logic [tft_pkg::TAN_W-1:0] tan[3];
		logic                      degen;
		tangent_t                  r;
		int                        slot;
		p[0] = v.px;
		p[1] = v.py;
		p[2] = v.pz;
		if (corners_held != tft_pkg::LAST_CORNER) begin
			slot = (corners_held == tft_pkg::MID_CORNER) ? 1 : 0;
			for (int k = 0; k < 3; k++)
				corner_pos[slot * 3 + k] = p[k];
			corner_uv[slot * 2] = v.tu;
			corner_uv[slot * 2 + 1] = v.tv;
			corners_held = 2'(slot + 1);
			return;
		end
		corners_held = '0;
		for (int k = 0; k < 3; k++) begin
			dp1[k] = corner_pos[3 + k] - corner_pos[k];
			dp2[k] = p[k] - corner_pos[k];
		end
		du1 = corner_uv[2] - corner_uv[0];
		dv1 = corner_uv[3] - corner_uv[1];
		du2 = v.tu - corner_uv[0];
		dv2 = v.tv - corner_uv[1];
		det = du1 * dv2 - dv1 * du2;
		degen = 1'b0;
		if (det == 0) begin
			degen = 1'b1;
			for (int k = 0; k < 3; k++)
				tan[k] = '0;
		end else begin
			wide = det;
			if (wide < 0)
				wide = -wide;
			det_mag = wide;
			for (int k = 0; k < 3; k++) begin
				num = dp1[k] * dv2 - dp2[k] * dv1;
				wide = num;
				if (wide < 0)
					wide = -wide;
				quo = wide;
				quo = (quo << FRAC) / det_mag;
				if (num[66] != det[66]) begin
					if (quo > 128'h8000_0000) begin
						tan[k] = tft_pkg::TAN_SAT_NEG;
						degen = 1'b1;
					end else begin
						tan[k] = 32'd0 - quo[31:0];
					end
				end else begin
					if (quo > 128'h7FFF_FFFF) begin
						tan[k] = tft_pkg::TAN_SAT_POS;
						degen = 1'b1;
					end else begin
						tan[k] = quo[31:0];
					end
				end
			end
		end
		for (int k = 0; k < 3; k++) begin
			r.tx = tan[0];
			r.ty = tan[1];
			r.tz = tan[2];
			r.corner = 2'(k);
			r.degen = degen;
			r.last = (2'(k) == tft_pkg::LAST_CORNER);
			tangents_due = {tangents_due, r};
		end
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			gap_left = 0;
		end else begin
			if (in_valid && !in_stall) begin
				absorb_vertex(on_wire);
				vertices_taken++;
			end
			if (!in_valid || !in_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (vertex_queue.size() != 0) begin
					on_wire = vertex_queue.pop_front();
					pos_x <= on_wire.px;
					pos_y <= on_wire.py;
					pos_z <= on_wire.pz;
					tex_u <= on_wire.tu;
					tex_v <= on_wire.tv;
					in_valid <= 1'b1;
					gap_left = pick_gap(((vertices_taken / 24) % 3) == 1);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		tangent_t want;
		if (!arst_n) begin
			out_stall <= 1'b1;
			hold_left = 0;
		end else begin
			if (out_valid && !out_stall) begin
				results_seen++;
				if (tangents_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected transfer: x=%0d y=%0d z=%0d corner=%0d",
							tangent_x, tangent_y, tangent_z, corner_index);
				end else begin
					want = tangents_due.pop_front();
					if (tangent_x !== want.tx || tangent_y !== want.ty ||
							tangent_z !== want.tz || corner_index !== want.corner ||
							degenerate !== want.degen || last_of_triangle !== want.last) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: want %0d %0d %0d c%0d d%0b l%0b, got %0d %0d %0d c%0d d%0b l%0b",
								$signed(want.tx), $signed(want.ty), $signed(want.tz),
								want.corner, want.degen, want.last, tangent_x, tangent_y,
								tangent_z, corner_index, degenerate, last_of_triangle);
					end
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
				hold_left = pick_gap(((results_seen / 30) % 3) == 2);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("tb_top failed");
				$finish;
			end
		end
	end

	initial begin
		int shape, reach, base_u, base_v, ou1, ov1, ou2, ov2, m, du, dv;

		// unit uv basis
		add_vertex(0, 0, 0, 0, 0);
		add_vertex(ONE, 0, 0, ONE, 0);
		add_vertex(0, ONE, 0, 0, ONE);
		// zero determinant
		add_vertex(ONE, 2 * ONE, 3 * ONE, ONE, ONE);
		add_vertex(-ONE, 5 * ONE, 0, ONE, ONE);
		add_vertex(7, -9, 11, ONE, ONE);
		// positive saturation
		add_vertex(0, 0, 0, 0, 0);
		add_vertex(Q_MAX, Q_MAX, Q_MAX, 1, 0);
		add_vertex(0, 0, 0, 0, 1);
		// negative saturation
		add_vertex(0, 0, 0, 0, 0);
		add_vertex(Q_MIN, Q_MIN, Q_MIN, 1, 0);
		add_vertex(0, 0, 0, 0, 1);
		// negative determinant
		add_vertex(ONE, ONE, ONE, 0, 0);
		add_vertex(3 * ONE, -ONE, ONE, 0, ONE);
		add_vertex(ONE, 2 * ONE, -5 * ONE, ONE, 0);
		// most negative tangent without saturation
		add_vertex(0, 0, 0, 0, 0);
		add_vertex(-32768, 32767, 0, 1, 0);
		add_vertex(5, -7, 9, 0, 1);
		// just past the limits
		add_vertex(0, 0, 0, 0, 0);
		add_vertex(32768, -32769, 0, 1, 0);
		add_vertex(0, 0, 0, 0, 1);
		// field extremes
		add_vertex(Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX);
		add_vertex(Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN);
		add_vertex(Q_MIN, Q_MAX, 0, Q_MAX, Q_MIN);

		repeat (RANDOM_TRIANGLES) begin
			shape = $urandom_range(0, 99);
			base_u = span(1 << 22);
			base_v = span(1 << 22);
			if (shape < 45) begin
				reach = 1 << 20;
				ou1 = span(1 << 18);
				ov1 = span(1 << 18);
				ou2 = span(1 << 18);
				ov2 = span(1 << 18);
			end else if (shape < 65) begin
				// collinear uv, or uv2 on uv0
				reach = 1 << 26;
				ou1 = span(1 << 18);
				ov1 = span(1 << 18);
				m = int'($urandom_range(0, 4)) - 2;
				ou2 = m * ou1;
				ov2 = m * ov1;
			end else if (shape < 80) begin
				reach = 1 << 29;
				ou1 = span(3);
				ov1 = span(3);
				ou2 = span(3);
				ov2 = span(3);
			end else begin
				reach = 1 << 16;
				ou1 = span(1 << 12);
				ov1 = span(1 << 12);
				ou2 = span(1 << 12);
				ov2 = span(1 << 12);
			end
			for (int k = 0; k < 3; k++) begin
				du = (k == 1) ? ou1 : (k == 2) ? ou2 : 0;
				dv = (k == 1) ? ov1 : (k == 2) ? ov2 : 0;
				if (shape < 15)
					add_vertex(int'($urandom), int'($urandom), int'($urandom),
						int'($urandom), int'($urandom));
				else
					add_vertex(span(reach), span(reach), span(reach), base_u + du,
						base_v + dv);
			end
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		while (vertex_queue.size() != 0 || in_valid || tangents_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && tangents_due.size() == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule
